[design/hnkm_pkg.sv]
// Package for the header name keyword matcher: widths, descriptor types,
// the character value table and the keyword table.
// No dependencies.
`default_nettype none

package hnkm_pkg;

  localparam int MAX_NAME_LEN = 21;
  localparam int NAME_W       = MAX_NAME_LEN * 8;
  localparam int HASH_W       = 13;
  localparam int LEN_W        = 5;
  localparam int KEY_W        = HASH_W + 1;
  localparam int SLOT_W       = 8;
  localparam int TYPE_W       = 6;

  localparam logic [HASH_W-1:0] HASH_MAX = '1;
  localparam logic [LEN_W-1:0]  LEN_MAX  = '1;
  localparam logic [LEN_W-1:0]  MIN_WORD = LEN_W'(2);
  localparam logic [LEN_W-1:0]  MAX_WORD = LEN_W'(21);
  localparam logic [KEY_W-1:0]  TOP_SLOT = KEY_W'(232);
  localparam logic [7:0]        NON_KEY  = 8'd233;
  localparam logic [TYPE_W-1:0] TYPE_MAX = TYPE_W'(53);

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // One finished name handed from the front end to the lookup side.
  // name: last char in the low byte, first char at byte len-1.
  typedef struct packed {
    logic                 ok;
    logic [SLOT_W-1:0]    slot;
    logic [LEN_W-1:0]     len;
    logic [NAME_W-1:0]    name;
  } desc_t;

  typedef struct packed {
    logic                 hit;
    logic [TYPE_W-1:0]    htype;
    logic [NAME_W-1:0]    word;
  } kw_rom_t;

  localparam logic [7:0] LETTER_VAL [26] = '{
    8'd0, 8'd0, 8'd54, 8'd20, 8'd0, 8'd15, 8'd35, 8'd10, 8'd0, 8'd15, 8'd0, 8'd30, 8'd55,
    8'd0, 8'd0, 8'd0, 8'd45, 8'd0, 8'd0, 8'd0, 8'd0, 8'd10, 8'd20, 8'd30, 8'd0, 8'd50
  };

  function automatic logic [7:0] char_value(input logic [7:0] c);
    logic [7:0] v;
    if (c inside {[8'h61:8'h7A]}) begin
      v = LETTER_VAL[5'(c - 8'h61)];
    end else if (c == 8'h2D) begin
      v = 8'd0;
    end else begin
      v = NON_KEY;
    end
    return v;
  endfunction

  function automatic kw_rom_t kw_entry(input logic [TYPE_W-1:0] t,
                                       input logic [NAME_W-1:0] w);
    kw_rom_t r;
    r.hit   = 1'b1;
    r.htype = t;
    r.word  = w;
    return r;
  endfunction

  // Word literals are right-justified: last char in byte 0, zeros above.
  function automatic kw_rom_t kw_lookup(input logic [SLOT_W-1:0] slot);
    kw_rom_t r;
    r = '0;
    case (slot)
      8'd2:   r = kw_entry(6'd1,  NAME_W'("to"));
      8'd5:   r = kw_entry(6'd2,  NAME_W'("route"));
      8'd6:   r = kw_entry(6'd0,  NAME_W'("reason"));
      8'd8:   r = kw_entry(6'd3,  NAME_W'("priority"));
      8'd12:  r = kw_entry(6'd0,  NAME_W'("response-key"));
      8'd13:  r = kw_entry(6'd4,  NAME_W'("via"));
      8'd14:  r = kw_entry(6'd0,  NAME_W'("path"));
      8'd15:  r = kw_entry(6'd5,  NAME_W'("event"));
      8'd16:  r = kw_entry(6'd6,  NAME_W'("server"));
      8'd23:  r = kw_entry(6'd7,  NAME_W'("refer-to"));
      8'd24:  r = kw_entry(6'd8,  NAME_W'("date"));
      8'd25:  r = kw_entry(6'd9,  NAME_W'("error-info"));
      8'd26:  r = kw_entry(6'd10, NAME_W'("retry-after"));
      8'd29:  r = kw_entry(6'd11, NAME_W'("supported"));
      8'd31:  r = kw_entry(6'd12, NAME_W'("unsupported"));
      8'd34:  r = kw_entry(6'd0,  NAME_W'("hide"));
      8'd37:  r = kw_entry(6'd13, NAME_W'("expires"));
      8'd38:  r = kw_entry(6'd14, NAME_W'("reply-to"));
      8'd41:  r = kw_entry(6'd15, NAME_W'("in-reply-to"));
      8'd45:  r = kw_entry(6'd16, NAME_W'("user-agent"));
      8'd46:  r = kw_entry(6'd17, NAME_W'("referred-by"));
      8'd49:  r = kw_entry(6'd0,  NAME_W'("rseq"));
      8'd52:  r = kw_entry(6'd18, NAME_W'("require"));
      8'd55:  r = kw_entry(6'd19, NAME_W'("alert-info"));
      8'd58:  r = kw_entry(6'd0,  NAME_W'("rack"));
      8'd59:  r = kw_entry(6'd0,  NAME_W'("p-asserted-identity"));
      8'd62:  r = kw_entry(6'd20, NAME_W'("warning"));
      8'd64:  r = kw_entry(6'd0,  NAME_W'("encryption"));
      8'd66:  r = kw_entry(6'd21, NAME_W'("content-type"));
      8'd71:  r = kw_entry(6'd0,  NAME_W'("privacy"));
      8'd72:  r = kw_entry(6'd22, NAME_W'("subscription-state"));
      8'd73:  r = kw_entry(6'd23, NAME_W'("authorization"));
      8'd74:  r = kw_entry(6'd24, NAME_W'("from"));
      8'd75:  r = kw_entry(6'd0,  NAME_W'("p-preferred-identity"));
      8'd76:  r = kw_entry(6'd25, NAME_W'("subject"));
      8'd79:  r = kw_entry(6'd26, NAME_W'("security-server"));
      8'd85:  r = kw_entry(6'd27, NAME_W'("allow"));
      8'd86:  r = kw_entry(6'd28, NAME_W'("record-route"));
      8'd88:  r = kw_entry(6'd29, NAME_W'("proxy-require"));
      8'd92:  r = kw_entry(6'd30, NAME_W'("replaces"));
      8'd93:  r = kw_entry(6'd31, NAME_W'("content-disposition"));
      8'd94:  r = kw_entry(6'd32, NAME_W'("security-verify"));
      8'd96:  r = kw_entry(6'd33, NAME_W'("min-expires"));
      8'd97:  r = kw_entry(6'd34, NAME_W'("organization"));
      8'd98:  r = kw_entry(6'd35, NAME_W'("authentication-info"));
      8'd102: r = kw_entry(6'd36, NAME_W'("allow-events"));
      8'd103: r = kw_entry(6'd37, NAME_W'("cseq"));
      8'd109: r = kw_entry(6'd38, NAME_W'("proxy-authorization"));
      8'd112: r = kw_entry(6'd39, NAME_W'("proxy-authenticate"));
      8'd114: r = kw_entry(6'd40, NAME_W'("accept"));
      8'd115: r = kw_entry(6'd41, NAME_W'("contact"));
      8'd119: r = kw_entry(6'd42, NAME_W'("timestamp"));
      8'd132: r = kw_entry(6'd43, NAME_W'("mime-version"));
      8'd138: r = kw_entry(6'd44, NAME_W'("call-info"));
      8'd140: r = kw_entry(6'd45, NAME_W'("www-authenticate"));
      8'd141: r = kw_entry(6'd46, NAME_W'("call-id"));
      8'd143: r = kw_entry(6'd47, NAME_W'("content-length"));
      8'd152: r = kw_entry(6'd48, NAME_W'("max-forwards"));
      8'd153: r = kw_entry(6'd49, NAME_W'("security-client"));
      8'd156: r = kw_entry(6'd0,  NAME_W'("p-media-authorization"));
      8'd170: r = kw_entry(6'd50, NAME_W'("content-language"));
      8'd179: r = kw_entry(6'd51, NAME_W'("content-encoding"));
      8'd223: r = kw_entry(6'd52, NAME_W'("accept-language"));
      8'd232: r = kw_entry(6'd53, NAME_W'("accept-encoding"));
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[design/hnkm_front.sv]
// Front end: takes characters, folds case, shifts them into the name
// register and keeps the running hash and length. Uses hnkm_pkg.
`default_nettype none

module hnkm_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [7:0]    in_tdata,   // [7:0] char_code
  input  wire logic          in_tlast,   // last_char
  input  wire logic          q_full,
  output logic               q_push,
  output hnkm_pkg::desc_t    q_desc
);
  import hnkm_pkg::*;

  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [NAME_W-1:0] name_r, name_nxt;
  logic [7:0]        c_lc;
  logic [KEY_W-1:0]  sum_ext;
  logic [HASH_W-1:0] sum_sat;
  logic [LEN_W-1:0]  len_inc;
  logic [KEY_W-1:0]  key;
  logic              accept;

  always_comb begin
    c_lc     = (in_tdata inside {[8'h41:8'h5A]}) ? in_tdata + 8'd32 : in_tdata;
    sum_ext  = {1'b0, hash_r} + KEY_W'(char_value(c_lc));
    sum_sat  = (sum_ext > {1'b0, HASH_MAX}) ? HASH_MAX : sum_ext[HASH_W-1:0];
    len_inc  = (len_r < LEN_MAX) ? len_r + 1'b1 : len_r;
    key      = {1'b0, sum_sat} + KEY_W'(len_inc);
    // shift line: newest char in byte 0
    name_nxt = {name_r[NAME_W-9:0], c_lc};

    in_tready = !q_full;
    accept    = in_tvalid && in_tready;
    q_push    = accept && in_tlast;

    q_desc.ok   = (len_inc >= MIN_WORD) && (len_inc <= MAX_WORD) && (key <= TOP_SLOT);
    q_desc.slot = key[SLOT_W-1:0];
    q_desc.len  = len_inc;
    q_desc.name = name_nxt;

    hash_nxt = hash_r;
    len_nxt  = len_r;
    if (accept) begin
      hash_nxt = in_tlast ? '0 : sum_sat;
      len_nxt  = in_tlast ? '0 : len_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= '0;
      len_r  <= '0;
    end else begin
      hash_r <= hash_nxt;
      len_r  <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      name_r <= name_nxt;
    end
  end

endmodule

`default_nettype wire

[design/hnkm_fifo.sv]
// Short descriptor queue between the front end and the lookup side.
// Uses hnkm_pkg for the descriptor type and depth.
`default_nettype none

module hnkm_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire hnkm_pkg::desc_t  push_desc,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output hnkm_pkg::desc_t       head_desc
);
  import hnkm_pkg::*;

  desc_t              mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  always_comb begin
    full       = (cnt_r == Q_CNT_W'(Q_DEPTH));
    head_valid = (cnt_r != '0);
    head_desc  = mem[rd_ptr_r];
    do_push    = push && !full;
    do_pop     = pop && head_valid;

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_desc;
    end
  end

endmodule

`default_nettype wire

[design/hnkm_back.sv]
// Lookup side: reads the keyword slot, then compares the name against the
// stored word and registers the result. Uses hnkm_pkg.
`default_nettype none

module hnkm_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  output logic                  q_pop,
  input  wire hnkm_pkg::desc_t  q_desc,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [7:0]            out_tdata   // [0] word_found, [6:1] header_type, [7] zero
);
  import hnkm_pkg::*;

  // lookup stage
  logic              s1_valid_r;
  logic              s1_ok_r;
  logic [LEN_W-1:0]  s1_len_r;
  logic [NAME_W-1:0] s1_name_r;
  kw_rom_t           s1_rom_r;

  // output register
  logic              out_valid_r;
  logic              out_found_r;
  logic [TYPE_W-1:0] out_type_r;

  logic              out_load, s1_adv, s1_load;
  logic              same;
  logic              found;
  logic [7:0]        nb, wb;

  always_comb begin
    out_load = !out_valid_r || out_tready;
    s1_adv   = s1_valid_r && out_load;
    s1_load  = !s1_valid_r || s1_adv;
    q_pop    = q_valid && s1_load;

    // bytes below the length must match; above it the word must be empty;
    // with ok set this forces equal lengths, as neither keyword chars nor ok name chars are zero
    same = 1'b1;
    for (int k = 0; k < MAX_NAME_LEN; k++) begin
      nb = s1_name_r[k*8 +: 8];
      wb = s1_rom_r.word[k*8 +: 8];
      if (LEN_W'(k) < s1_len_r) begin
        if (nb != wb) same = 1'b0;
      end else begin
        if (wb != 8'd0) same = 1'b0;
      end
    end
    found = s1_ok_r && s1_rom_r.hit && same;

    out_tvalid = out_valid_r;
    out_tdata  = {1'b0, out_type_r, out_found_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= q_valid;
      end
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_ok_r   <= q_desc.ok;
      s1_len_r  <= q_desc.len;
      s1_name_r <= q_desc.name;
      s1_rom_r  <= kw_lookup(q_desc.slot);
    end
    if (s1_adv) begin
      out_found_r <= found;
      out_type_r  <= found ? s1_rom_r.htype : '0;
    end
  end

endmodule

`default_nettype wire

[design/header_name_keyword_matcher.sv]
// Header name keyword matcher, top level. One character per cycle is taken
// while the queue is not full; a result leaves after the last character's
// transfer (queue write, slot lookup register, compare into output reg).
// Throughput is set by the front end's hash/length update: 1 char/cycle.
// Synchronous active-low reset clears hash, length, queue and valids; the
// name register needs no reset and there is no clearing pass.
`default_nettype none

module header_name_keyword_matcher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_code
  input  wire logic        in_tlast,   // last_char
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata   // [0] word_found, [6:1] header_type, [7] zero
);
  import hnkm_pkg::*;

  logic  q_push, q_full, q_pop, q_valid;
  desc_t push_desc, head_desc;

  hnkm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_desc    (push_desc)
  );

  hnkm_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_desc  (push_desc),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_desc  (head_desc)
  );

  hnkm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_desc     (head_desc),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef ASSERT_OFF
  a_type_needs_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[6:1] == '0)
    else $error("header type set without a match");

  a_type_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[6:1] <= TYPE_MAX && out_tdata[7] == 1'b0)
    else $error("result code out of range");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_push_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("name descriptor pushed into full queue");
`endif

endmodule

`default_nettype wire

[test/hnkm_scoreboard.sv]
// Scoreboard for the header name keyword matcher: watches the character and
// result streams, predicts each lookup from its own keyword table and compares.
// Depends on hnkm_pkg for widths and length/slot limits.
module hnkm_scoreboard (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  output int         error_cnt,
  output int         pending_cnt,
  output int         result_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  import hnkm_pkg::*;

  typedef struct packed {
    logic              found;
    logic [TYPE_W-1:0] htype;
  } lookup_t;

  localparam int         KW_NUM         = 64;
  localparam logic [7:0] CH_HYPHEN      = 8'h2D;
  localparam logic [7:0] NON_KEY_WEIGHT = 8'd233;

  localparam logic [7:0] LETTER_WEIGHT [26] = '{
    8'd0, 8'd0, 8'd54, 8'd20, 8'd0, 8'd15, 8'd35, 8'd10, 8'd0, 8'd15, 8'd0, 8'd30, 8'd55,
    8'd0, 8'd0, 8'd0, 8'd45, 8'd0, 8'd0, 8'd0, 8'd0, 8'd10, 8'd20, 8'd30, 8'd0, 8'd50
  };

  localparam int KW_SLOT [KW_NUM] = '{
    2, 5, 6, 8, 12, 13, 14, 15, 16, 23,
    24, 25, 26, 29, 31, 34, 37, 38, 41, 45,
    46, 49, 52, 55, 58, 59, 62, 64, 66, 71,
    72, 73, 74, 75, 76, 79, 85, 86, 88, 92,
    93, 94, 96, 97, 98, 102, 103, 109, 112, 114,
    115, 119, 132, 138, 140, 141, 143, 152, 153, 156,
    170, 179, 223, 232
  };

  // 0 marks a table word that maps to no supported header
  localparam int KW_TYPE [KW_NUM] = '{
    1, 2, 0, 3, 0, 4, 0, 5, 6, 7,
    8, 9, 10, 11, 12, 0, 13, 14, 15, 16,
    17, 0, 18, 19, 0, 0, 20, 0, 21, 0,
    22, 23, 24, 0, 25, 26, 27, 28, 29, 30,
    31, 32, 33, 34, 35, 36, 37, 38, 39, 40,
    41, 42, 43, 44, 45, 46, 47, 48, 49, 0,
    50, 51, 52, 53
  };

  string kw_word [KW_NUM] = '{
    "to", "route", "reason", "priority", "response-key", "via", "path", "event",
    "server", "refer-to", "date", "error-info", "retry-after", "supported",
    "unsupported", "hide", "expires", "reply-to", "in-reply-to", "user-agent",
    "referred-by", "rseq", "require", "alert-info", "rack", "p-asserted-identity",
    "warning", "encryption", "content-type", "privacy", "subscription-state",
    "authorization", "from", "p-preferred-identity", "subject", "security-server",
    "allow", "record-route", "proxy-require", "replaces", "content-disposition",
    "security-verify", "min-expires", "organization", "authentication-info",
    "allow-events", "cseq", "proxy-authorization", "proxy-authenticate", "accept",
    "contact", "timestamp", "mime-version", "call-info", "www-authenticate",
    "call-id", "content-length", "max-forwards", "security-client",
    "p-media-authorization", "content-language", "content-encoding",
    "accept-language", "accept-encoding"
  };

  logic [HASH_W-1:0] hash_acc;
  logic [LEN_W-1:0]  name_cnt;
  logic [7:0]        name_chars [MAX_NAME_LEN];
  lookup_t           lookups [$];
  int                errs;
  int                results;

  initial begin
    hash_acc    = '0;
    name_cnt    = '0;
    errs        = 0;
    results     = 0;
    error_cnt   = 0;
    pending_cnt = 0;
    result_cnt  = 0;
  end

  function automatic logic [7:0] weight_of(input logic [7:0] c);
    logic [7:0] w;
    if (c >= 8'h61 && c <= 8'h7A) begin
      w = LETTER_WEIGHT[5'(c - 8'h61)];
    end else if (c == CH_HYPHEN) begin
      w = 8'd0;
    end else begin
      w = NON_KEY_WEIGHT;
    end
    return w;
  endfunction

  // Slot is hash plus length; the word stored there must match in length
  // and in every (already lower-cased) character.
  function automatic lookup_t lookup_name();
    lookup_t r;
    int      key;
    int      idx;
    logic    same;
    r   = '0;
    idx = -1;
    key = int'(hash_acc) + int'(name_cnt);
    if (name_cnt >= MIN_WORD && name_cnt <= MAX_WORD && key <= int'(TOP_SLOT)) begin
      for (int i = 0; i < KW_NUM; i++) begin
        if (KW_SLOT[i] == key) idx = i;
      end
      if (idx >= 0 && kw_word[idx].len() == int'(name_cnt)) begin
        same = 1'b1;
        for (int k = 0; k < kw_word[idx].len(); k++) begin
          if (name_chars[k] != kw_word[idx][k]) same = 1'b0;
        end
        if (same) begin
          r.found = 1'b1;
          r.htype = TYPE_W'(KW_TYPE[idx]);
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    logic [7:0] c;
    int         sum;
    lookup_t    want;
    if (!rst_n) begin
      hash_acc = '0;
      name_cnt = '0;
      lookups.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        c = in_tdata;
        if (c >= 8'h41 && c <= 8'h5A) c = c + 8'h20;
        if (int'(name_cnt) < MAX_NAME_LEN) name_chars[name_cnt] = c;
        sum      = int'(hash_acc) + int'(weight_of(c));
        hash_acc = (sum > int'(HASH_MAX)) ? HASH_MAX : HASH_W'(sum);
        if (name_cnt != LEN_MAX) name_cnt = name_cnt + 1'b1;
        if (in_tlast) begin
          lookups.push_back(lookup_name());
          hash_acc = '0;
          name_cnt = '0;
        end
      end
      if (out_tvalid && out_tready) begin
        results++;
        if (lookups.size() == 0) begin
          if (errs < 10)
            $display("mismatch: result %0d (data %h) with no lookup pending",
                     results, out_tdata);
          errs++;
        end else begin
          want = lookups.pop_front();
          if (out_tdata[0] !== want.found || out_tdata[6:1] !== want.htype ||
              out_tdata[7] !== 1'b0) begin
            if (errs < 10)
              $display({"mismatch: result %0d expected found=%0b type=%0d, ",
                        "got found=%0b type=%0d pad=%0b"}, results, want.found,
                       want.htype, out_tdata[0], out_tdata[6:1], out_tdata[7]);
            errs++;
          end
        end
      end
    end
    error_cnt   <= errs;
    pending_cnt <= lookups.size();
    result_cnt  <= results;
  end

endmodule

[test/tb.sv]
// Top testbench for the header name keyword matcher: clock, reset, character
// stimulus and result-side back-pressure; the scoreboard does the checking.
// Depends on header_name_keyword_matcher, hnkm_scoreboard and hnkm_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         KW_NUM      = 64;
  localparam int         CHAR_TARGET = 900;
  localparam int         HOLD_CYCLES = 300;
  localparam int         HOLD_AFTER  = 450;
  localparam int         STALL_LIMIT = 5000;
  localparam logic [7:0] CH_HYPHEN   = 8'h2D;
  localparam logic [7:0] CH_A_LOWER  = 8'h61;
  localparam logic [7:0] CH_A_UPPER  = 8'h41;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tready = 1'b0;
  logic       in_tready;
  logic       out_tvalid;
  logic [7:0] out_tdata;

  int   error_cnt;
  int   pending_cnt;
  int   result_cnt;
  int   chars_sent  = 0;
  int   names_sent  = 0;
  int   idle_cycles = 0;
  bit   tx_steady   = 1'b0;
  bit   rx_steady   = 1'b0;
  bit   held_off    = 1'b0;
  logic [7:0] name_bytes [$];

  string kw_list [KW_NUM] = '{
    "to", "route", "reason", "priority", "response-key", "via", "path", "event",
    "server", "refer-to", "date", "error-info", "retry-after", "supported",
    "unsupported", "hide", "expires", "reply-to", "in-reply-to", "user-agent",
    "referred-by", "rseq", "require", "alert-info", "rack", "p-asserted-identity",
    "warning", "encryption", "content-type", "privacy", "subscription-state",
    "authorization", "from", "p-preferred-identity", "subject", "security-server",
    "allow", "record-route", "proxy-require", "replaces", "content-disposition",
    "security-verify", "min-expires", "organization", "authentication-info",
    "allow-events", "cseq", "proxy-authorization", "proxy-authenticate", "accept",
    "contact", "timestamp", "mime-version", "call-info", "www-authenticate",
    "call-id", "content-length", "max-forwards", "security-client",
    "p-media-authorization", "content-language", "content-encoding",
    "accept-language", "accept-encoding"
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  header_name_keyword_matcher dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  hnkm_scoreboard sb (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .error_cnt   (error_cnt),
    .pending_cnt (pending_cnt),
    .result_cnt  (result_cnt)
  );

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    int g;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      g = 0;
    end else if (r < 92) begin
      g = $urandom_range(1, 3);
    end else begin
      g = $urandom_range(8, 40);
    end
    return g;
  endfunction

  // letter of either case, or a hyphen
  function automatic logic [7:0] rand_name_char();
    logic [7:0] c;
    if ($urandom_range(0, 7) == 0) begin
      c = CH_HYPHEN;
    end else if ($urandom_range(0, 1) == 1) begin
      c = CH_A_UPPER + 8'($urandom_range(0, 25));
    end else begin
      c = CH_A_LOWER + 8'($urandom_range(0, 25));
    end
    return c;
  endfunction

  task automatic send_name();
    int gap;
    for (int i = 0; i < name_bytes.size(); i++) begin
      in_tvalid <= 1'b1;
      in_tdata  <= name_bytes[i];
      in_tlast  <= (i == name_bytes.size() - 1);
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      chars_sent++;
      gap = tx_steady ? 0 : pick_gap();
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    names_sent++;
  endtask

  task automatic send_text(input string s);
    name_bytes.delete();
    for (int i = 0; i < s.len(); i++) name_bytes.push_back(s[i]);
    send_name();
  endtask

  // no transfer on either side for too long means a hang
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin : result_side
    int stall;
    stall = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      // one long hold-off so the block backs up and stalls the input
      if (!held_off && chars_sent >= HOLD_AFTER) begin
        held_off = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if ($urandom_range(0, 49) == 0) rx_steady = !rx_steady;
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        if (!rx_steady) stall = pick_gap();
      end
    end
  end

  initial begin : char_side
    string word;
    int    pick;
    int    pos;
    int    n;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: shortest keyword, too short, upper case, word with no type,
    // byte extremes, slot hit with wrong text, case-fold boundaries
    send_text("To");
    send_text("a");
    send_text("VIA");
    send_text("hide");
    name_bytes.delete();
    name_bytes.push_back(8'h00);
    name_bytes.push_back(8'hFF);
    send_name();
    send_text("tp");
    send_text("@[");
    name_bytes.delete();
    name_bytes.push_back(8'h60);
    name_bytes.push_back(8'h7B);
    send_name();

    while (chars_sent < CHAR_TARGET) begin
      if ($urandom_range(0, 11) == 0) tx_steady = !tx_steady;
      word = kw_list[$urandom_range(0, KW_NUM - 1)];
      // every twentieth name is overlong so length and hash may saturate
      pick = (names_sent % 20 == 7) ? 99 : $urandom_range(0, 99);
      name_bytes.delete();
      if (pick < 82) begin
        for (int i = 0; i < word.len(); i++) name_bytes.push_back(word[i]);
      end
      if (pick < 50) begin
        for (int i = 0; i < name_bytes.size(); i++) begin
          if (name_bytes[i] != CH_HYPHEN && $urandom_range(0, 1) == 1)
            name_bytes[i] = name_bytes[i] - 8'h20;
        end
      end else if (pick < 62) begin
        pos = $urandom_range(0, name_bytes.size() - 1);
        name_bytes[pos] = rand_name_char();
      end else if (pick < 70) begin
        pos = $urandom_range(0, name_bytes.size() - 1);
        name_bytes[pos] = 8'($urandom_range(0, 255));
      end else if (pick < 76) begin
        n = $urandom_range(1, name_bytes.size() - 1);
        while (name_bytes.size() > n) void'(name_bytes.pop_back());
      end else if (pick < 82) begin
        n = $urandom_range(1, 3);
        repeat (n) name_bytes.push_back(rand_name_char());
      end else if (pick < 90) begin
        n = $urandom_range(1, 21);
        repeat (n) name_bytes.push_back(rand_name_char());
      end else if (pick < 96) begin
        n = $urandom_range(1, 8);
        repeat (n) name_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        n = $urandom_range(22, 70);
        repeat (n) begin
          if ($urandom_range(0, 1) == 1) begin
            name_bytes.push_back(rand_name_char());
          end else begin
            name_bytes.push_back(8'($urandom_range(0, 255)));
          end
        end
      end
      send_name();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("summary: %0d characters in %0d names, %0d lookup results checked",
             chars_sent, names_sent, result_cnt);
    $display({"summary: keywords in mixed case, mutated, cut short and padded, ",
              "random bytes, overlong names, one long result-side hold-off"});
    if (error_cnt == 0 && pending_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

[header_name_keyword_matcher.f]
design/hnkm_pkg.sv
design/hnkm_front.sv
design/hnkm_fifo.sv
design/hnkm_back.sv
design/header_name_keyword_matcher.sv
test/hnkm_scoreboard.sv
test/tb.sv
